// ----- hdl/least_cost_venue_selector_macros.svh -----
// ---------------------------------------------------------------------------
// least_cost_venue_selector_macros
// Assertion macros for the venue selector; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LEAST_COST_VENUE_SELECTOR_MACROS_SVH
`define LEAST_COST_VENUE_SELECTOR_MACROS_SVH
`ifndef SYNTH
`define LCVS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LCVS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define LCVS_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define LCVS_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- hdl/lcvs_pkg.sv -----
// ---------------------------------------------------------------------------
// lcvs_pkg
// Types and constants of the least-cost venue selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package lcvs_pkg;
	localparam int VENUE_COUNT = 5;
	localparam int FEE_REGS    = 5;
	localparam int VIDX_W      = (VENUE_COUNT > 1) ? $clog2(VENUE_COUNT) : 1;
	localparam int CFG_IDX_W   = 3;
	localparam int FEE_IDX_W   = 3;

	localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
	localparam logic [12:0] TENTH_Q16 = 13'd6554;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_ROUTE  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [2:0]  venue;
		logic [31:0] spread;
		logic [31:0] liquidity;
		logic [31:0] quantity;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  best_venue;
		logic [33:0] best_cost;
	} out_item_t;
endpackage

// ----- hdl/least_cost_venue_selector.sv -----
// ---------------------------------------------------------------------------
// least_cost_venue_selector
// Picks the venue of least spread + fee + impact for a routed order.
// ---------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes update and route requests.
//   An update writes one venue's spread and liquidity, no result.
//   A route walks the venues one at a time on a single shared 35-bit
//   subtract/compare unit: 64 restoring divide steps for quantity*2^32/liq,
//   then 32 square root steps, a multiply and an add/compare.
//   A venue with zero liquidity goes straight to the add/compare.
//   in_ready is high only while no request is in progress.
//   out channel (out_valid/out_ready/out_data) holds one result register;
//   a new request is taken while a result waits. A route that finishes
//   while the previous result is still held waits for out_ready.
//   cfg channel writes fee registers, always ready; bad indexes are ignored.
//   Reset clears fees, stores and the result valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "least_cost_venue_selector_macros.svh"
module least_cost_venue_selector
	import lcvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_SQRT  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_ACC   = 3'd5;

	logic [2:0]        state_q;
	logic [VIDX_W-1:0] cnt_q;
	logic [5:0]        step_q;
	logic [31:0]       fee_q [FEE_REGS];
	logic [31:0]       spread_q [VENUE_COUNT];
	logic [31:0]       liq_q [VENUE_COUNT];
	logic [31:0]       qty_q;
	logic [34:0]       rem_q;
	logic [63:0]       work_q;
	logic [31:0]       root_q;
	logic [31:0]       imp_q;
	logic [33:0]       best_cost_q;
	logic [VIDX_W-1:0] best_idx_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [34:0] sub_a, sub_b;
	logic [35:0] diff;
	logic        ge;
	logic [31:0] fee_sel, liq_sel, spread_sel;
	logic [44:0] prod;
	logic [33:0] cost;
	logic        take;
	logic        last;
	logic        out_free;
	logic        in_acc;
	logic        done;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign liq_sel    = liq_q[cnt_q];
	assign spread_sel = spread_q[cnt_q];
	assign fee_sel    = (32'(cnt_q) < FEE_REGS) ? fee_q[FEE_IDX_W'(cnt_q)] : 32'd0;

	always_comb begin
		if (state_q == S_SQRT) begin
			sub_a = {rem_q[32:0], work_q[63:62]};
			sub_b = {1'b0, root_q, 2'b01};
		end else begin
			sub_a = {rem_q[33:0], work_q[63]};
			sub_b = {3'b000, liq_sel};
		end
	end
	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = !diff[35];

	assign prod = 45'(root_q) * 45'(TENTH_Q16);
	assign cost = 34'(spread_sel) + 34'(fee_sel) + 34'(imp_q);
	assign take = (cnt_q == '0) || (cost < best_cost_q);
	assign last = (32'(cnt_q) == VENUE_COUNT - 1);
	assign done = (state_q == S_ACC) && last && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FEE_REGS; i++) fee_q[i] <= '0;
		end else if (cfg_valid && 32'(cfg_index) < FEE_REGS) begin
			fee_q[FEE_IDX_W'(cfg_index)] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VENUE_COUNT; i++) begin
				spread_q[i] <= '0;
				liq_q[i]    <= '0;
			end
		end else if (in_acc && in_data.kind == KIND_UPDATE) begin
			for (int i = 0; i < VENUE_COUNT; i++) begin
				if (32'(in_data.venue) == i) begin
					spread_q[i] <= in_data.spread;
					liq_q[i]    <= in_data.liquidity;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_data.kind == KIND_ROUTE) begin
						cnt_q   <= '0;
						state_q <= S_START;
					end
				end
				S_START: begin
					step_q  <= '0;
					state_q <= (liq_sel == '0) ? S_ACC : S_DIV;
				end
				S_DIV: begin
					if (step_q == 6'd63) begin
						step_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				S_SQRT: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd31) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (!last) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_START;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) qty_q <= in_data.quantity;
		unique case (state_q)
			S_START: begin
				rem_q  <= '0;
				root_q <= '0;
				work_q <= {qty_q, 32'd0};
				imp_q  <= ONE_Q16;
			end
			S_DIV: begin
				rem_q  <= (step_q == 6'd63) ? '0 : (ge ? diff[34:0] : sub_a);
				work_q <= {work_q[62:0], ge};
			end
			S_SQRT: begin
				rem_q  <= ge ? diff[34:0] : sub_a;
				root_q <= {root_q[30:0], ge};
				work_q <= {work_q[61:0], 2'b00};
			end
			S_MUL: imp_q <= {3'b000, prod[44:16]};
			S_ACC: begin
				if (!last) begin
					if (take) begin
						best_cost_q <= cost;
						best_idx_q  <= cnt_q;
					end
				end else if (out_free) begin
					out_q.best_venue <= take ? 3'(cnt_q) : 3'(best_idx_q);
					out_q.best_cost  <= take ? cost : best_cost_q;
				end
			end
			default: ;
		endcase
	end

	`LCVS_ASSERT_NXT(a_route_busy, clk, arst_n, in_acc && in_data.kind == KIND_ROUTE, !in_ready)
	`LCVS_ASSERT_NXT(a_update_idle, clk, arst_n, in_acc && in_data.kind == KIND_UPDATE, in_ready)
	`LCVS_ASSERT_IMP(a_result_src, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_ACC)
	`LCVS_ASSERT_NXT(a_result_hold, clk, arst_n, out_valid_q && !out_ready, out_valid_q && $stable(out_q))
endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the least-cost venue selector. Venue metric updates and route
// requests go in under random idling on both channels across several fee
// settings; a scoreboard predicts each route result from its own copy of the
// fees and venue stores and checks every result field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
	import lcvs_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ROUTE_CYCLES = 1 + 99 * VENUE_COUNT;
	localparam int PEND_DEPTH = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		FEE_V0 = 3'd0, FEE_V1 = 3'd1, FEE_V2 = 3'd2, FEE_V3 = 3'd3, FEE_V4 = 3'd4
	} fee_reg_e;

	class route_scoreboard;
		logic [31:0] fee [FEE_REGS];
		logic [31:0] spread_q [VENUE_COUNT];
		logic [31:0] liq_q [VENUE_COUNT];
		out_item_t pending [PEND_DEPTH];
		int head;
		int tail;
		int errors;
		int routes;

		function new();
			foreach (fee[i]) fee[i] = '0;
			foreach (spread_q[i]) begin
				spread_q[i] = '0;
				liq_q[i] = '0;
			end
			head = 0;
			tail = 0;
			errors = 0;
			routes = 0;
		endfunction

		function int outstanding();
			return tail - head;
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] n);
			logic [63:0] root, b;
			root = '0;
			b = 64'h4000_0000_0000_0000;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= root + b) begin
					n = n - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		function logic [33:0] impact(logic [31:0] qty, logic [31:0] liq);
			logic [63:0] ratio;
			logic [79:0] prod;
			if (liq == 0) return 34'(ONE_Q16);
			ratio = {qty, 32'h0} / {32'h0, liq};
			prod = {16'h0, int_sqrt(ratio)} * 80'd6554;
			return 34'(prod >> 16);
		endfunction

		function void set_fee(int idx, logic [31:0] val);
			if (idx < FEE_REGS) fee[idx] = val;
		endfunction

		function void note_request(in_item_t it);
			out_item_t r;
			logic [33:0] c;
			if (it.kind == KIND_UPDATE) begin
				if (it.venue < VENUE_COUNT) begin
					spread_q[it.venue] = it.spread;
					liq_q[it.venue] = it.liquidity;
				end
				return;
			end
			for (int i = 0; i < VENUE_COUNT; i++) begin
				c = 34'(spread_q[i]) + 34'(fee[i]) + impact(it.quantity, liq_q[i]);
				if (i == 0 || c < r.best_cost) begin
					r.best_cost = c;
					r.best_venue = 3'(i);
				end
			end
			pending[tail % PEND_DEPTH] = r;
			tail++;
		endfunction

		task report(string what, logic [63:0] e, logic [63:0] g);
			errors++;
			if (errors <= 30)
				$display("MISMATCH %s: expected %0h got %0h", what, e, g);
		endtask

		task check_result(out_item_t got);
			out_item_t exp_r;
			routes++;
			if (outstanding() == 0) begin
				report("unexpected result", 0, got.best_venue);
				return;
			end
			exp_r = pending[head % PEND_DEPTH];
			head++;
			if (got.best_venue !== exp_r.best_venue)
				report("best_venue", exp_r.best_venue, got.best_venue);
			if (got.best_cost !== exp_r.best_cost)
				report("best_cost", exp_r.best_cost, got.best_cost);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int send_idle = 0;
	int recv_stall = 0;
	int cycles = 0;
	route_scoreboard sb;

	always #10 clk = ~clk;

	least_cost_venue_selector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic write_fee(fee_reg_e idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_fee(idx, val);
	endtask

	task automatic send(in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_request(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (ROUTE_CYCLES + 20) @(posedge clk);
	endtask

	function automatic in_item_t mk(logic k, logic [2:0] v, logic [31:0] s,
			logic [31:0] l, logic [31:0] q);
		in_item_t it;
		it.kind = k;
		it.venue = v;
		it.spread = s;
		it.liquidity = l;
		it.quantity = q;
		return it;
	endfunction

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(255);
			3: return $urandom_range(32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	task automatic set_fees(int mode);
		for (int i = 0; i < FEE_REGS; i++)
			write_fee(fee_reg_e'(i), mode == 0 ? 32'h0 : mode == 1 ? 32'hFFFF_FFFF :
				mode == 2 ? 32'($urandom_range(32'h0002_0000)) : $urandom);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		in_item_t it;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero stores, extremes, ties, out-of-range venues
		send(mk(KIND_ROUTE, 3'd0, 32'h0, 32'h0, 32'h0));
		send(mk(KIND_ROUTE, 3'd0, 32'h0, 32'h0, 32'hFFFF_FFFF));
		send(mk(KIND_UPDATE, 3'd2, 32'h0, 32'hFFFF_FFFF, 32'h0));
		send(mk(KIND_ROUTE, 3'd7, 32'hFFFF_FFFF, 32'h1, 32'h0));
		send(mk(KIND_ROUTE, 3'd0, 32'h0, 32'h0, 32'hFFFF_FFFF));
		send(mk(KIND_UPDATE, 3'd0, 32'hFFFF_FFFF, 32'h1, 32'h0));
		send(mk(KIND_UPDATE, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		send(mk(KIND_UPDATE, 3'd3, 32'h0, 32'h1, 32'hFFFF_FFFF));
		send(mk(KIND_UPDATE, 3'd4, 32'hFFFF_FFFF, 32'h0, 32'h0));
		send(mk(KIND_ROUTE, 3'd0, 32'h0, 32'h0, 32'hFFFF_FFFF));
		send(mk(KIND_ROUTE, 3'd0, 32'h0, 32'h0, 32'h1));
		send(mk(KIND_UPDATE, 3'd5, 32'h0, 32'h5, 32'h0));
		send(mk(KIND_UPDATE, 3'd6, 32'h1234, 32'h0, 32'h0));
		send(mk(KIND_UPDATE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		send(mk(KIND_ROUTE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1));
		drain();
		set_fees(1);
		send(mk(KIND_ROUTE, 3'd0, 32'h0, 32'h0, 32'hFFFF_FFFF));
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 76; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 76; end
				3: begin send_idle = 31; recv_stall = 31; end
				default: begin send_idle = $urandom_range(50); recv_stall = 0; end
			endcase
			set_fees(ph % 4);
			for (int n = 0; n < 80; n++) begin
				it.kind = ($urandom_range(99) < 45) ? KIND_ROUTE : KIND_UPDATE;
				it.venue = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) :
					3'($urandom_range(VENUE_COUNT - 1));
				it.spread = rnd_word();
				it.liquidity = rnd_word();
				it.quantity = rnd_word();
				send(it);
			end
			drain();
		end

		$display("covered %0d route results over 5 fee settings and idling phases",
			sb.routes);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
